// ===== hw/rtl/fub_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fub_pkg: shared definitions of the fire upward blur filter
// Frame limits, field widths, register indexes, kernel operand bundle and the
// constant dividers used by the blur kernel.
// ----------------------------------------------------------------------------
package fub_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CFG_W = 10;

  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 4;

  localparam logic [COL_W-1:0] WIDTH_LAST_RST  = COL_W'(320 - 1);
  localparam logic [ROW_W-1:0] HEIGHT_LAST_RST = ROW_W'(240 - 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  // Window: entries 0/1 are row r-2 at columns c-2/c-1, 2/3 row r-1, 4/5 row r.
  typedef pix_t [5:0] win_t;

  typedef struct packed {
    win_t win;
    pix_t older_pix;
    pix_t newer_pix;
    pix_t cur_pix;
    logic full_weight;
  } kernel_in_t;

  // Last column index of a frame, with the width clamped to its legal range.
  function automatic col_t width_last(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] eff;
    if (v < CFG_W'(MIN_WIDTH)) begin
      eff = CFG_W'(MIN_WIDTH);
    end else if (v > CFG_W'(MAX_WIDTH)) begin
      eff = CFG_W'(MAX_WIDTH);
    end else begin
      eff = v;
    end
    return COL_W'(eff - CFG_W'(1));
  endfunction

  function automatic row_t height_last(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] eff;
    if (v < CFG_W'(MIN_HEIGHT)) begin
      eff = CFG_W'(MIN_HEIGHT);
    end else if (v > CFG_W'(MAX_HEIGHT)) begin
      eff = CFG_W'(MAX_HEIGHT);
    end else begin
      eff = v;
    end
    return ROW_W'(eff - CFG_W'(1));
  endfunction

  // Sum of at most 12*255 divided by 12: divide by 4 with a shift, then by 3
  // with the reciprocal 683/2048, exact for quotients of up to 765.
  function automatic pix_t div12(input logic [11:0] s);
    logic [19:0] p;
    p = 20'(s[11:2]) * 20'd683;
    return p[18:11];
  endfunction

  // Sum of at most 7*255 divided by 7 through the reciprocal 2341/16384.
  function automatic pix_t div7(input logic [10:0] s);
    logic [21:0] p;
    p = 22'(s) * 22'd2341;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fub_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fub_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module fub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fub_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fub_kernel: blur and decay of one destination pixel
// Weighted window sum, constant divide by 12 or 7, minus one clamped at zero.
// ----------------------------------------------------------------------------
module fub_kernel (
  input  wire fub_pkg::kernel_in_t k_in,
  output fub_pkg::pix_t            value
);

  import fub_pkg::*;

  logic [11:0] five_cur;
  logic [11:0] full_sum;
  logic [10:0] part_sum;
  pix_t        quot;

  always_comb begin
    five_cur = (12'(k_in.win[5]) << 2) + 12'(k_in.win[5]);
    full_sum = 12'(k_in.win[0]) + 12'(k_in.older_pix) + 12'(k_in.win[2])
             + 12'(k_in.win[3]) + 12'(k_in.newer_pix) + 12'(k_in.win[4])
             + five_cur + 12'(k_in.cur_pix);
    part_sum = 11'(12'(k_in.win[3]) + five_cur + 12'(k_in.cur_pix));
    quot     = k_in.full_weight ? div12(full_sum) : div7(part_sum);
    value    = (quot != '0) ? quot - PIX_W'(1) : '0;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fire_upward_blur_filter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fire_upward_blur_filter_unit: upward blur of a streamed fire heat frame
// Turns a raster stream of 8-bit heat pixels into blurred, decayed
// destination pixels of rows 1 to height-3, with zero on the edge columns.
// ----------------------------------------------------------------------------
// The unit accepts one heat pixel per clock and sustains that rate through a
// whole frame while out_ready stays high. The line store is read at the edge
// that accepts a pixel, which also loads the kernel stage, and the kernel
// result is loaded into the output register when that stage moves on; a pixel
// with a result waits in the kernel stage until the output register is free.
// The last pixel of a line causes two result transactions (its blurred
// neighbor and the zero right edge), which hold the output register in turn;
// the following first pixel of the next line causes none, so the average
// stays at one per clock. Rows 0 to 2 of the source produce no results, and
// neither do rows height-2, height-1 and 0 of the destination. Writing
// frame_width or frame_height restarts the frame at column 0, row 0 and should
// only be done while no transaction is in flight. The line store is one
// dual-port RAM of MAX_WIDTH entries and needs no clearing after reset.
// ----------------------------------------------------------------------------
module fire_upward_blur_filter_unit (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Heat pixel input
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire fub_pkg::pix_t          in_heat_pixel,
  // Blurred pixel output
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [8:0]                  out_column,
  output logic [8:0]                  out_row,
  output fub_pkg::pix_t               out_value,
  output logic                        out_last_of_item,
  // Configuration writes
  input  wire logic                   cfg_wr_en,
  input  wire fub_pkg::cfg_idx_t      cfg_index,
  input  wire logic [fub_pkg::CFG_W-1:0] cfg_data
);

  import fub_pkg::*;

  // Geometry, held as last column and last row index after clamping.
  col_t width_last_r;
  row_t height_last_r;

  // Position of the next pixel to be accepted.
  col_t col_r, col_nxt;
  row_t row_r, row_nxt;

  // Kernel stage.
  logic s1_valid_r, s1_valid_nxt;
  pix_t s1_px_r;
  col_t s1_col_r;
  row_t s1_row_r;
  logic s1_row_end_r;
  logic s1_frame_end_r;

  win_t win_r, win_nxt;
  logic weight_r, weight_nxt;

  // Output register plus the pending zero right-edge result.
  logic out_valid_r, out_valid_nxt;
  logic pend_r, pend_nxt;
  logic [8:0] out_column_r;
  logic [8:0] out_row_r;
  pix_t out_value_r;
  logic out_last_r;

  logic in_acc;
  logic out_free;
  logic s1_has_out;
  logic s1_computed;
  logic s1_go;
  logic s1_load_out;

  logic [2*PIX_W-1:0] line_rd;
  logic [2*PIX_W-1:0] line_wr;
  pix_t older_pix;
  pix_t newer_pix;

  kernel_in_t k_in;
  pix_t       k_value;

  // ---------------------------------------------------------------------------
  // Handshake and stage control. The kernel stage moves on whenever its pixel
  // causes no result, or the output register is free this cycle: empty, or
  // being taken with no right-edge result still waiting behind it.
  // ---------------------------------------------------------------------------
  assign out_free    = !out_valid_r || (out_ready && !pend_r);
  assign s1_has_out  = (s1_row_r >= ROW_W'(3)) && (s1_col_r != '0);
  assign s1_computed = (s1_row_r >= ROW_W'(3)) && (s1_col_r >= COL_W'(2));
  assign s1_go       = s1_valid_r && (!s1_has_out || out_free);
  assign s1_load_out = s1_go && s1_has_out;
  assign in_ready    = !s1_valid_r || s1_go;
  assign in_acc      = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Line store: the upper byte holds source row r-2, the lower byte row r-1,
  // both at the column of the pixel. Consecutive pixels touch different
  // columns since a line has at least three, so the write of the kernel stage
  // never collides with the read of the input stage.
  // ---------------------------------------------------------------------------
  assign older_pix = line_rd[2*PIX_W-1:PIX_W];
  assign newer_pix = line_rd[PIX_W-1:0];
  assign line_wr   = {newer_pix, s1_px_r};

  fub_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (line_rd)
  );

  // ---------------------------------------------------------------------------
  // Blur kernel on the window, the two line store bytes and the new pixel.
  // ---------------------------------------------------------------------------
  always_comb begin
    k_in.win         = win_r;
    k_in.older_pix   = older_pix;
    k_in.newer_pix   = newer_pix;
    k_in.cur_pix     = s1_px_r;
    k_in.full_weight = weight_r;
  end

  fub_kernel u_kernel (
    .k_in  (k_in),
    .value (k_value)
  );

  // ---------------------------------------------------------------------------
  // Next-state logic.
  // ---------------------------------------------------------------------------
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    s1_valid_nxt  = s1_valid_r;
    win_nxt       = win_r;
    weight_nxt    = weight_r;
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;

    // Raster position advances with every accepted pixel.
    if (in_acc) begin
      if (col_r == width_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == height_last_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end

    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end

    // The window shifts by one column with every pixel that moves on; the weight flag
    // alternates on every computed pixel and returns to full weight at frame start.
    if (s1_go) begin
      win_nxt = {s1_px_r, win_r[5], newer_pix, win_r[3], older_pix, win_r[1]};
      if (s1_frame_end_r) begin
        weight_nxt = 1'b1;
      end else if (s1_computed) begin
        weight_nxt = !weight_r;
      end
    end

    if (s1_load_out) begin
      out_valid_nxt = 1'b1;
      pend_nxt      = s1_row_end_r;
    end else if (out_valid_r && out_ready) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end

    // A write to either geometry register restarts the frame.
    if (cfg_wr_en) begin
      col_nxt    = '0;
      row_nxt    = '0;
      weight_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= WIDTH_LAST_RST;
      height_last_r <= HEIGHT_LAST_RST;
      col_r         <= '0;
      row_r         <= '0;
      s1_valid_r    <= 1'b0;
      win_r         <= '0;
      weight_r      <= 1'b1;
      out_valid_r   <= 1'b0;
      pend_r        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_last_r  <= width_last(cfg_data);
          CFG_FRAME_HEIGHT: height_last_r <= height_last(cfg_data);
          default: ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      win_r       <= win_nxt;
      weight_r    <= weight_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers. The kernel stage keeps the pixel with its position and
  // its line and frame end marks. The output register takes the kernel result
  // (column 0 of a line carries zero), or the zero right-edge result after the
  // first of a pair has been taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r        <= in_heat_pixel;
      s1_col_r       <= col_r;
      s1_row_r       <= row_r;
      s1_row_end_r   <= (col_r == width_last_r);
      s1_frame_end_r <= (col_r == width_last_r) && (row_r == height_last_r);
    end
    if (s1_load_out) begin
      out_column_r <= 9'(s1_col_r - COL_W'(1));
      out_row_r    <= 9'(s1_row_r - ROW_W'(2));
      out_value_r  <= s1_computed ? k_value : '0;
      out_last_r   <= !s1_row_end_r;
    end else if (out_valid_r && out_ready && pend_r) begin
      out_column_r <= 9'(width_last_r);
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column       = out_column_r;
  assign out_row          = out_row_r;
  assign out_value        = out_value_r;
  assign out_last_of_item = out_last_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A right-edge result waits exactly while the first of a pair is shown.
  a_pend_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == (out_valid_r && !out_last_r))
    else $error("pending edge result out of step with the output register");

  // Input is only held off by a busy kernel stage.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r)
    else $error("input stalled with an empty kernel stage");

  // A stalled kernel stage keeps its pixel.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_px_r)))
    else $error("kernel stage lost a stalled pixel");

  // A result is only loaded into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load_out |-> (!out_valid_r || (out_ready && !pend_r)))
    else $error("output register overwritten");

endmodule
`default_nettype wire

// ===== tb/tb_fire_upward_blur_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fire_upward_blur_filter_unit: self-checking bench of the fire blur unit
// Streams heat frames of many geometries through the unit, predicts every
// blurred destination pixel in the bench and checks each output transaction
// field by field, with and without random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_fire_upward_blur_filter_unit;
  import fub_pkg::*;

  // Divisors of the two kernels and the first source row that produces output.
  localparam int unsigned FULL_DIV       = 12;
  localparam int unsigned LIGHT_DIV      = 7;
  localparam int unsigned FIRST_OUT_ROW  = 3;
  // Cycles allowed after the last expected result before the unit counts as
  // idle; a pixel that causes no result can still be in the kernel stage.
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          RANDOM_ITEMS   = 150;

  typedef struct packed {
    logic [8:0] column;
    logic [8:0] row;
    pix_t       value;
    logic       last;
  } blur_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  pix_t             in_heat_pixel;
  logic             out_valid;
  logic             out_ready;
  logic [8:0]       out_column;
  logic [8:0]       out_row;
  pix_t             out_value;
  logic             out_last_of_item;
  logic             cfg_wr_en;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  fire_upward_blur_filter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_heat_pixel    (in_heat_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column       (out_column),
    .out_row          (out_row),
    .out_value        (out_value),
    .out_last_of_item (out_last_of_item),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 2 ns clock period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Bench copy of the unit's state. Past its zeroing at start, only the monitor
  // writes it, at rising edges, so it always reflects transactions seen so far.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width_reg  = CFG_W'(320);
  logic [CFG_W-1:0] frame_height_reg = CFG_W'(240);
  pix_t             line_two_up [MAX_WIDTH];
  pix_t             line_one_up [MAX_WIDTH];
  pix_t             blur_win    [6];
  int unsigned      next_col    = 0;
  int unsigned      next_row    = 0;
  logic             full_kernel = 1'b1;

  blur_result_t     expected_blur_q [$];
  int               fault_count = 0;

  // When set, the sender leaves random gaps and the receiver stalls at random.
  logic             bubbles_on = 1'b0;

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_two_up[i] = '0;
      line_one_up[i] = '0;
    end
    for (int i = 0; i < 6; i++) begin
      blur_win[i] = '0;
    end
  end

  function automatic blur_result_t blur_result(input int unsigned col, input int unsigned row,
                                               input int unsigned val);
    blur_result_t res;
    res.column = 9'(col);
    res.row    = 9'(row);
    res.value  = pix_t'(val);
    res.last   = 1'b0;
    return res;
  endfunction

  // Works out the destination pixels that one accepted heat pixel releases and
  // queues them in order, then advances the line stores, window and position.
  task automatic predict_blur(input pix_t px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  sum;
    int unsigned  q;
    int           n;
    pix_t         two_up;
    pix_t         one_up;
    blur_result_t res_a;
    blur_result_t res_b;

    // Out-of-range geometry is clamped to the legal range.
    w = (frame_width_reg < CFG_W'(MIN_WIDTH)) ? MIN_WIDTH :
        (frame_width_reg > CFG_W'(MAX_WIDTH)) ? MAX_WIDTH : 32'(frame_width_reg);
    h = (frame_height_reg < CFG_W'(MIN_HEIGHT)) ? MIN_HEIGHT :
        (frame_height_reg > CFG_W'(MAX_HEIGHT)) ? MAX_HEIGHT : 32'(frame_height_reg);
    c = (next_col >= w) ? w - 1 : next_col;
    r = (next_row >= h) ? h - 1 : next_row;
    two_up = line_two_up[c];
    one_up = line_one_up[c];
    n = 0;

    if (r >= FIRST_OUT_ROW) begin
      if (c == 1) begin
        // The left edge column is released as zero by the second pixel.
        res_a = blur_result(0, r - 2, 0);
        n = 1;
      end else if (c >= 2) begin
        if (full_kernel) begin
          sum = blur_win[0] + two_up + blur_win[2] + blur_win[3] + one_up
              + blur_win[4] + 5 * blur_win[5] + px;
          q = sum / FULL_DIV;
        end else begin
          sum = blur_win[3] + 5 * blur_win[5] + px;
          q = sum / LIGHT_DIV;
        end
        q = (q > 0) ? q - 1 : 0;
        full_kernel = ~full_kernel;
        res_a = blur_result(c - 1, r - 2, q);
        n = 1;
        if (c == w - 1) begin
          // The last pixel of a line also releases the zero right edge.
          res_b = blur_result(w - 1, r - 2, 0);
          n = 2;
        end
      end
    end

    if (n == 1) begin
      res_a.last = 1'b1;
      expected_blur_q.push_back(res_a);
    end else if (n == 2) begin
      res_b.last = 1'b1;
      expected_blur_q.push_back(res_a);
      expected_blur_q.push_back(res_b);
    end

    blur_win[0] = blur_win[1];
    blur_win[1] = two_up;
    blur_win[2] = blur_win[3];
    blur_win[3] = one_up;
    blur_win[4] = blur_win[5];
    blur_win[5] = px;
    line_two_up[c] = one_up;
    line_one_up[c] = px;

    if (c + 1 >= w) begin
      next_col = 0;
      if (r + 1 >= h) begin
        // New frame: the weight pattern starts over with the full kernel.
        next_row    = 0;
        full_kernel = 1'b1;
      end else begin
        next_row = r + 1;
      end
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Register writes, input transactions and output transactions are
  // all taken from the values present just before the rising edge. Inputs are
  // predicted first, so an expectation is always queued before its result
  // can show up at the output.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    blur_result_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        // Any register write restarts the frame at column 0, row 0.
        if (cfg_index == CFG_FRAME_WIDTH) begin
          frame_width_reg = cfg_data;
        end else begin
          frame_height_reg = cfg_data;
        end
        next_col    = 0;
        next_row    = 0;
        full_kernel = 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_blur(in_heat_pixel);
      end
      if (out_valid && out_ready) begin
        if (expected_blur_q.size() == 0) begin
          $error("result with none expected: column %0d row %0d value %0d",
                 out_column, out_row, out_value);
          fault_count++;
        end else begin
          want = expected_blur_q.pop_front();
          if (out_column !== want.column) begin
            $error("out_column: expected %0d, actual %0d", want.column, out_column);
            fault_count++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, actual %0d", want.row, out_row);
            fault_count++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, actual %0d", want.value, out_value);
            fault_count++;
          end
          if (out_last_of_item !== want.last) begin
            $error("out_last_of_item: expected %0d, actual %0d", want.last,
                   out_last_of_item);
            fault_count++;
          end
        end
      end
    end
  end

  // Receiver: while bubbles are on, out_ready drops at random, else it stays high.
  // Each edge carries at most one assignment to out_ready.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (bubbles_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks. Each is entered right after a rising edge.
  // --------------------------------------------------------------------------

  // Offers one heat pixel and returns at the edge where it was accepted. A gap
  // lowers valid first; a back-to-back pixel keeps valid high and only changes
  // the payload, so valid never sees two assignments at one edge.
  task automatic send_heat(input pix_t px);
    if (bubbles_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_heat_pixel <= px;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random heat, leaning on the extremes so saturated and empty windows occur.
  function automatic pix_t random_heat();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_heat(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_heat(random_heat());
    end
  endtask

  // Stops the input and waits for an edge, so the monitor has queued what the
  // last pixel releases, then until every expected result has been taken, and
  // then through SETTLE_CYCLES for pixels that are still in the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_blur_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the unit idle.
  task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset geometry is 320 x 240: three source lines plus a few pixels of the
  // fourth must release destination row 1 with the edge at column 0.
  task automatic test_reset_geometry();
    bubbles_on = 1'b0;
    send_random_heat(3 * 320 + 8);
  endtask

  // Smallest frames with saturated and nearly empty windows: all-255 gives the
  // largest blurred value, and the 4-wide frame has one light-kernel pixel.
  task automatic test_extreme_pixels();
    bubbles_on = 1'b1;
    set_geometry(3, 4);
    for (int i = 0; i < 12; i++) begin
      send_heat(8'hFF);
    end
    write_reg(CFG_FRAME_WIDTH, 4);
    for (int i = 0; i < 16; i++) begin
      send_heat((i % 5 == 0) ? 8'hFF : 8'h01);
    end
  endtask

  // Register values below the legal range clamp to the smallest frame, which
  // is sent twice after the first setting to show where it wraps.
  task automatic test_clamped_geometry();
    bubbles_on = 1'b1;
    set_geometry(0, 0);
    send_random_heat(2 * 3 * 4);
    set_geometry(2, 3);
    send_random_heat(3 * 4);
    set_geometry(1, 1);
    send_random_heat(3 * 4);
  endtask

  // A write restarts the frame even when it leaves the value unchanged, here
  // after frames broken off in the middle of a line.
  task automatic test_restart_on_write();
    bubbles_on = 1'b1;
    set_geometry(6, 5);
    send_random_heat(6 * 4 + 2);
    write_reg(CFG_FRAME_WIDTH, 6);
    send_random_heat(6 * 5);
    send_random_heat(6 * 3 + 1);
    write_reg(CFG_FRAME_HEIGHT, 5);
    send_random_heat(6 * 5);
  endtask

  // Random geometries, mostly narrow and short so results come often, with
  // whole frames and sometimes a broken-off frame before the next write.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned count;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      bubbles_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(3, 16);
      h = $urandom_range(4, 9);
      set_geometry(w, h);
      count = $urandom_range(1, 3) * w * h;
      if ($urandom_range(0, 2) == 0) begin
        count += $urandom_range(1, w * h - 1);
      end
      if (count > RANDOM_ITEMS - sent) begin
        count = RANDOM_ITEMS - sent;
      end
      send_random_heat(count);
      sent += count;
    end
  endtask

  // Back-to-back pixels with the receiver always ready.
  task automatic test_steady_stream();
    bubbles_on = 1'b0;
    set_geometry(9, 6);
    send_random_heat(2 * 9 * 6);
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_heat_pixel <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_FRAME_WIDTH;
    cfg_data      <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_geometry();
    test_extreme_pixels();
    test_clamped_geometry();
    test_restart_on_write();
    test_random_frames();
    test_steady_stream();

    drain();
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run of all the tests above.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fub_pkg.sv
hw/rtl/fub_ram.sv
hw/rtl/fub_kernel.sv
hw/rtl/fire_upward_blur_filter_unit.sv
tb/tb_fire_upward_blur_filter_unit.sv
